// ===== hw/rtl/exu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// exu_pkg
// types, codes and constants shared by the execute unit front, queue and back
// ----------------------------------------------------------------------------
package exu_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] SP_RESET     = 8'hFD;
    localparam logic [7:0] STATUS_RESET = 8'h24;
    localparam logic [7:0] PUSH_P_MASK  = 8'h30;
    localparam logic [7:0] SIGN_MASK    = 8'h80;
    localparam logic [7:0] ALL_ONES     = 8'hFF;
    localparam logic [7:0] ONE          = 8'h01;

    // status bit positions, N V U B D I Z C
    localparam logic [2:0] FLAG_C = 3'd0;
    localparam logic [2:0] FLAG_Z = 3'd1;
    localparam logic [2:0] FLAG_I = 3'd2;
    localparam logic [2:0] FLAG_D = 3'd3;
    localparam logic [2:0] FLAG_B = 3'd4;
    localparam logic [2:0] FLAG_U = 3'd5;
    localparam logic [2:0] FLAG_V = 3'd6;
    localparam logic [2:0] FLAG_N = 3'd7;

    // register select codes
    localparam logic [1:0] REG_A  = 2'd0;
    localparam logic [1:0] REG_X  = 2'd1;
    localparam logic [1:0] REG_Y  = 2'd2;
    localparam logic [1:0] REG_SP = 2'd3;

    typedef enum logic [4:0] {
        FN_LOAD  = 5'd0,
        FN_STORE = 5'd1,
        FN_ADD   = 5'd2,
        FN_SUB   = 5'd3,
        FN_AND   = 5'd4,
        FN_OR    = 5'd5,
        FN_XOR   = 5'd6,
        FN_CMP   = 5'd7,
        FN_BIT   = 5'd8,
        FN_ASL   = 5'd9,
        FN_LSR   = 5'd10,
        FN_ROL   = 5'd11,
        FN_ROR   = 5'd12,
        FN_INC   = 5'd13,
        FN_DEC   = 5'd14,
        FN_XFER  = 5'd15,
        FN_FLAG  = 5'd16,
        FN_RLA   = 5'd17,
        FN_BRA   = 5'd18,
        FN_PUSHA = 5'd19,
        FN_PUSHP = 5'd20,
        FN_PULLA = 5'd21,
        FN_PULLP = 5'd22,
        FN_NOP   = 5'd23
    } func_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_STORE,
        OP_ADC,
        OP_SBC,
        OP_AND,
        OP_ORA,
        OP_EOR,
        OP_CMP,
        OP_BIT,
        OP_SHIFT,
        OP_INCDEC,
        OP_XFER,
        OP_FLAG,
        OP_RLA,
        OP_BRANCH,
        OP_PUSH,
        OP_PULL
    } op_t;

    typedef enum logic [1:0] {
        SH_ASL = 2'd0,
        SH_LSR = 2'd1,
        SH_ROL = 2'd2,
        SH_ROR = 2'd3
    } shift_t;

    typedef struct packed {
        op_t         op;
        shift_t      shift;
        logic        alt;         // dec for inc/dec, status for push/pull
        logic [1:0]  reg_sel;
        logic [1:0]  src_sel;
        logic [7:0]  operand;
        logic        on_memory;
        logic [2:0]  flag_sel;
        logic        flag_value;
        logic        set_flags;
    } item_t;

    function automatic logic [7:0] reg_read(
        input logic [7:0] a,
        input logic [7:0] x,
        input logic [7:0] y,
        input logic [7:0] sp,
        input logic [1:0] sel
    );
        logic [7:0] r;
        case (sel)
            REG_A:   r = a;
            REG_X:   r = x;
            REG_Y:   r = y;
            default: r = sp;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/exu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// exu_front
// accepts items and classifies the function code into an operation class
// ----------------------------------------------------------------------------
module exu_front (
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [4:0]     func,
    input  wire logic [1:0]     reg_sel,
    input  wire logic [1:0]     src_sel,
    input  wire logic [7:0]     operand,
    input  wire logic           on_memory,
    input  wire logic [2:0]     flag_sel,
    input  wire logic           flag_value,
    input  wire logic           transfer_sets_flags,
    output logic                q_valid,
    input  wire logic           q_ready,
    output exu_pkg::item_t      q_item
);
    import exu_pkg::*;

    assign in_ready = q_ready;
    assign q_valid  = in_valid;

    always_comb
    begin
        q_item            = '0;
        q_item.op         = OP_NOP;
        q_item.shift      = SH_ASL;
        q_item.reg_sel    = reg_sel;
        q_item.src_sel    = src_sel;
        q_item.operand    = operand;
        q_item.on_memory  = on_memory;
        q_item.flag_sel   = flag_sel;
        q_item.flag_value = flag_value;
        q_item.set_flags  = transfer_sets_flags;
        case (func)
            FN_LOAD:  q_item.op = OP_LOAD;
            FN_STORE: q_item.op = OP_STORE;
            FN_ADD:   q_item.op = OP_ADC;
            FN_SUB:   q_item.op = OP_SBC;
            FN_AND:   q_item.op = OP_AND;
            FN_OR:    q_item.op = OP_ORA;
            FN_XOR:   q_item.op = OP_EOR;
            FN_CMP:   q_item.op = OP_CMP;
            FN_BIT:   q_item.op = OP_BIT;
            FN_ASL:
            begin
                q_item.op    = OP_SHIFT;
                q_item.shift = SH_ASL;
            end
            FN_LSR:
            begin
                q_item.op    = OP_SHIFT;
                q_item.shift = SH_LSR;
            end
            FN_ROL:
            begin
                q_item.op    = OP_SHIFT;
                q_item.shift = SH_ROL;
            end
            FN_ROR:
            begin
                q_item.op    = OP_SHIFT;
                q_item.shift = SH_ROR;
            end
            FN_INC:   q_item.op = OP_INCDEC;
            FN_DEC:
            begin
                q_item.op  = OP_INCDEC;
                q_item.alt = 1'b1;
            end
            FN_XFER:  q_item.op = OP_XFER;
            FN_FLAG:
            begin
                // b and u are fixed in the stored status
                if (flag_sel inside {FLAG_B, FLAG_U})
                    q_item.op = OP_NOP;
                else
                    q_item.op = OP_FLAG;
            end
            FN_RLA:   q_item.op = OP_RLA;
            FN_BRA:   q_item.op = OP_BRANCH;
            FN_PUSHA: q_item.op = OP_PUSH;
            FN_PUSHP:
            begin
                q_item.op  = OP_PUSH;
                q_item.alt = 1'b1;
            end
            FN_PULLA: q_item.op = OP_PULL;
            FN_PULLP:
            begin
                q_item.op  = OP_PULL;
                q_item.alt = 1'b1;
            end
            default:  q_item.op = OP_NOP;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/exu_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// exu_queue
// short fifo of classified items between the front and the back
// ----------------------------------------------------------------------------
module exu_queue #(
    parameter int DEPTH = exu_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire exu_pkg::item_t push_item,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output exu_pkg::item_t      pop_item
);
    import exu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (push && count_reg == '0) |=> pop_valid)
        else $error("item pushed into empty queue not visible");

endmodule
`default_nettype wire

// ===== hw/rtl/exu_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// exu_back
// register file, status byte, alu and registered result stage
// ----------------------------------------------------------------------------
module exu_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire exu_pkg::item_t q_item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          write_data,
    output logic                write_enable,
    output logic [8:0]          stack_address,
    output logic                branch_taken,
    output logic [7:0]          acc_out,
    output logic [7:0]          x_out,
    output logic [7:0]          y_out,
    output logic [7:0]          sp_out,
    output logic [7:0]          status_out
);
    import exu_pkg::*;

    logic [7:0] a_reg, a_next;
    logic [7:0] x_reg, x_next;
    logic [7:0] y_reg, y_next;
    logic [7:0] sp_reg, sp_next;
    logic [7:0] p_reg, p_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] wd_reg, wd_next;
    logic       we_reg, we_next;
    logic [8:0] sa_reg, sa_next;
    logic       bt_reg, bt_next;
    logic       exec_fire;

    logic       reg_wr;
    logic [1:0] reg_wr_sel;
    logic [7:0] reg_wr_val;
    logic       nz_upd;
    logic [7:0] nz_val;
    logic [7:0] rsel_val;
    logic [7:0] src_val;
    logic [7:0] m_val;
    logic [8:0] sum9;
    logic [8:0] diff9;
    logic [7:0] sh_res;
    logic       sh_c;
    logic [7:0] step_val;
    logic [7:0] sp_inc;
    logic       cin;

    assign exec_fire = q_valid && (!out_valid_reg || out_ready);
    assign q_ready   = !out_valid_reg || out_ready;

    always_comb
    begin
        a_next     = a_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        sp_next    = sp_reg;
        p_next     = p_reg;
        wd_next    = '0;
        we_next    = 1'b0;
        sa_next    = {1'b1, 8'h00};
        bt_next    = 1'b0;
        reg_wr     = 1'b0;
        reg_wr_sel = q_item.reg_sel;
        reg_wr_val = '0;
        nz_upd     = 1'b0;
        nz_val     = '0;
        cin        = p_reg[FLAG_C];
        rsel_val   = reg_read(a_reg, x_reg, y_reg, sp_reg, q_item.reg_sel);
        src_val    = q_item.on_memory ? q_item.operand : a_reg;
        m_val      = (q_item.op == OP_SBC) ? ~q_item.operand : q_item.operand;
        sum9       = {1'b0, a_reg} + {1'b0, m_val} + {8'b0, cin};
        diff9      = {1'b0, rsel_val} - {1'b0, q_item.operand};
        sp_inc     = sp_reg + ONE;
        step_val   = (q_item.on_memory ? q_item.operand : rsel_val);
        step_val   = q_item.alt ? step_val - ONE : step_val + ONE;

        case (q_item.shift)
            SH_ASL:
            begin
                sh_res = {src_val[6:0], 1'b0};
                sh_c   = src_val[7];
            end
            SH_LSR:
            begin
                sh_res = {1'b0, src_val[7:1]};
                sh_c   = src_val[0];
            end
            SH_ROL:
            begin
                sh_res = {src_val[6:0], cin};
                sh_c   = src_val[7];
            end
            default:
            begin
                sh_res = {cin, src_val[7:1]};
                sh_c   = src_val[0];
            end
        endcase

        case (q_item.op)
            OP_LOAD:
            begin
                reg_wr     = 1'b1;
                reg_wr_val = q_item.operand;
                nz_upd     = 1'b1;
                nz_val     = q_item.operand;
            end
            OP_STORE:
            begin
                wd_next = rsel_val;
                we_next = 1'b1;
            end
            OP_ADC, OP_SBC:
            begin
                p_next[FLAG_C] = sum9[8];
                p_next[FLAG_V] = (a_reg[7] ^ sum9[7]) & (m_val[7] ^ sum9[7]);
                reg_wr         = 1'b1;
                reg_wr_sel     = REG_A;
                reg_wr_val     = sum9[7:0];
                nz_upd         = 1'b1;
                nz_val         = sum9[7:0];
            end
            OP_AND, OP_ORA, OP_EOR:
            begin
                reg_wr     = 1'b1;
                reg_wr_sel = REG_A;
                if (q_item.op == OP_AND)
                    reg_wr_val = a_reg & q_item.operand;
                else if (q_item.op == OP_ORA)
                    reg_wr_val = a_reg | q_item.operand;
                else
                    reg_wr_val = a_reg ^ q_item.operand;
                nz_upd     = 1'b1;
                nz_val     = reg_wr_val;
            end
            OP_CMP:
            begin
                p_next[FLAG_C] = !diff9[8];
                nz_upd         = 1'b1;
                nz_val         = diff9[7:0];
            end
            OP_BIT:
            begin
                p_next[FLAG_Z] = ((a_reg & q_item.operand) == '0);
                p_next[FLAG_N] = q_item.operand[7];
                p_next[FLAG_V] = q_item.operand[6];
            end
            OP_SHIFT:
            begin
                p_next[FLAG_C] = sh_c;
                nz_upd         = 1'b1;
                nz_val         = sh_res;
                if (q_item.on_memory)
                begin
                    wd_next = sh_res;
                    we_next = 1'b1;
                end
                else
                begin
                    reg_wr     = 1'b1;
                    reg_wr_sel = REG_A;
                    reg_wr_val = sh_res;
                end
            end
            OP_INCDEC:
            begin
                nz_upd = 1'b1;
                nz_val = step_val;
                if (q_item.on_memory)
                begin
                    wd_next = step_val;
                    we_next = 1'b1;
                end
                else
                begin
                    reg_wr     = 1'b1;
                    reg_wr_val = step_val;
                end
            end
            OP_XFER:
            begin
                reg_wr     = 1'b1;
                reg_wr_val = reg_read(a_reg, x_reg, y_reg, sp_reg, q_item.src_sel);
                nz_upd     = q_item.set_flags;
                nz_val     = reg_wr_val;
            end
            OP_FLAG:
                p_next[q_item.flag_sel] = q_item.flag_value;
            OP_RLA:
            begin
                p_next[FLAG_C] = q_item.operand[7];
                wd_next        = {q_item.operand[6:0], cin};
                we_next        = 1'b1;
                reg_wr         = 1'b1;
                reg_wr_sel     = REG_A;
                reg_wr_val     = a_reg & {q_item.operand[6:0], cin};
                nz_upd         = 1'b1;
                nz_val         = reg_wr_val;
            end
            OP_BRANCH:
                bt_next = (p_reg[q_item.flag_sel] == q_item.flag_value);
            OP_PUSH:
            begin
                sa_next = {1'b1, sp_reg};
                wd_next = q_item.alt ? (p_reg | PUSH_P_MASK) : a_reg;
                we_next = 1'b1;
                sp_next = sp_reg - ONE;
            end
            OP_PULL:
            begin
                sp_next = sp_inc;
                sa_next = {1'b1, sp_inc};
                if (q_item.alt)
                begin
                    p_next         = q_item.operand;
                    p_next[FLAG_B] = 1'b0;
                    p_next[FLAG_U] = 1'b1;
                end
                else
                begin
                    reg_wr     = 1'b1;
                    reg_wr_sel = REG_A;
                    reg_wr_val = q_item.operand;
                    nz_upd     = 1'b1;
                    nz_val     = q_item.operand;
                end
            end
            default:
            begin
                p_next = p_reg;
            end
        endcase

        if (reg_wr)
        begin
            case (reg_wr_sel)
                REG_A:   a_next  = reg_wr_val;
                REG_X:   x_next  = reg_wr_val;
                REG_Y:   y_next  = reg_wr_val;
                default: sp_next = reg_wr_val;
            endcase
        end

        if (nz_upd)
        begin
            p_next[FLAG_Z] = (nz_val == '0);
            p_next[FLAG_N] = ((nz_val & SIGN_MASK) != '0);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg         <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            sp_reg        <= SP_RESET;
            p_reg         <= STATUS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (exec_fire)
            begin
                a_reg  <= a_next;
                x_reg  <= x_next;
                y_reg  <= y_next;
                sp_reg <= sp_next;
                p_reg  <= p_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            wd_reg <= wd_next;
            we_reg <= we_next;
            sa_reg <= sa_next;
            bt_reg <= bt_next;
        end
    end

    // registers only move on execute, so they match the held result
    assign out_valid     = out_valid_reg;
    assign write_data    = wd_reg;
    assign write_enable  = we_reg;
    assign stack_address = sa_reg;
    assign branch_taken  = bt_reg;
    assign acc_out       = a_reg;
    assign x_out         = x_reg;
    assign y_out         = y_reg;
    assign sp_out        = sp_reg;
    assign status_out    = p_reg;

    a_status_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        p_reg[FLAG_U] && !p_reg[FLAG_B])
        else $error("status u or b bit corrupted");

    a_push_sp: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && q_item.op == OP_PUSH) |=> sp_reg == 8'($past(sp_reg) - ONE))
        else $error("push did not decrement stack pointer");

    a_branch_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && q_item.op == OP_BRANCH) |=> out_valid_reg && !we_reg)
        else $error("branch test produced a write");

endmodule
`default_nettype wire

// ===== hw/rtl/cpu_execute_unit_8bit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_execute_unit_8bit
// execute stage of an 8-bit accumulator cpu: a, x, y, sp and status byte
// ----------------------------------------------------------------------------
// One item is taken per clock cycle with no bubbles while the queue has room. An
// accepted item is classified and written into a short queue; the back end
// executes the head of the queue against the register file and status byte and
// registers the result, so out_valid rises once the item has passed the queue
// and the result registers. Each item needs the registers left by the one before
// it. The queue absorbs output stalls, so in_ready stays high until it is full.
// acc_out, x_out, y_out, sp_out and status_out show the registers after the item
// now on the output.
// ----------------------------------------------------------------------------
module cpu_execute_unit_8bit #(
    parameter int QUEUE_DEPTH = exu_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [4:0] func,
    input  wire logic [1:0] reg_sel,
    input  wire logic [1:0] src_sel,
    input  wire logic [7:0] operand,
    input  wire logic       on_memory,
    input  wire logic [2:0] flag_sel,
    input  wire logic       flag_value,
    input  wire logic       transfer_sets_flags,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      write_data,
    output logic            write_enable,
    output logic [8:0]      stack_address,
    output logic            branch_taken,
    output logic [7:0]      acc_out,
    output logic [7:0]      x_out,
    output logic [7:0]      y_out,
    output logic [7:0]      sp_out,
    output logic [7:0]      status_out
);
    import exu_pkg::*;

    item_t front_item;
    item_t head_item;
    logic  front_valid;
    logic  front_ready;
    logic  head_valid;
    logic  head_ready;

    exu_front u_front (
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .func                (func),
        .reg_sel             (reg_sel),
        .src_sel             (src_sel),
        .operand             (operand),
        .on_memory           (on_memory),
        .flag_sel            (flag_sel),
        .flag_value          (flag_value),
        .transfer_sets_flags (transfer_sets_flags),
        .q_valid             (front_valid),
        .q_ready             (front_ready),
        .q_item              (front_item)
    );

    exu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_item   (head_item)
    );

    exu_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (head_valid),
        .q_ready       (head_ready),
        .q_item        (head_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .write_data    (write_data),
        .write_enable  (write_enable),
        .stack_address (stack_address),
        .branch_taken  (branch_taken),
        .acc_out       (acc_out),
        .x_out         (x_out),
        .y_out         (y_out),
        .sp_out        (sp_out),
        .status_out    (status_out)
    );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the 8-bit cpu execute unit: a scoreboard model of
// a, x, y, sp and the status byte predicts every result, which is compared
// field by field as it leaves the block under random idling on both sides
// ----------------------------------------------------------------------------
module tb_top;
    import exu_pkg::*;

    localparam int  CHUNK_ITEMS = 250;
    localparam int  CHUNKS      = 8;
    localparam int  DRAIN_WAIT  = 8;
    localparam longint CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic [4:0] func;
        logic [1:0] rsel;
        logic [1:0] ssel;
        logic [7:0] operand;
        logic       on_mem;
        logic [2:0] fsel;
        logic       fval;
        logic       tflags;
    } exec_item_t;

    typedef struct packed {
        logic [7:0] wdata;
        logic       wen;
        logic [8:0] saddr;
        logic       taken;
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] p;
    } exec_result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [4:0] func;
    logic [1:0] reg_sel;
    logic [1:0] src_sel;
    logic [7:0] operand;
    logic       on_memory;
    logic [2:0] flag_sel;
    logic       flag_value;
    logic       transfer_sets_flags;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] write_data;
    logic       write_enable;
    logic [8:0] stack_address;
    logic       branch_taken;
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
    logic [7:0] sp_out;
    logic [7:0] status_out;

    // shadow register file
    logic [7:0] reg_a;
    logic [7:0] reg_x;
    logic [7:0] reg_y;
    logic [7:0] reg_sp;
    logic [7:0] reg_p;

    exec_result_t step_results_q[$];
    int          errors;
    longint      cycles;
    bit          idle_on;
    int          stall_left;

    cpu_execute_unit_8bit dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .func                (func),
        .reg_sel             (reg_sel),
        .src_sel             (src_sel),
        .operand             (operand),
        .on_memory           (on_memory),
        .flag_sel            (flag_sel),
        .flag_value          (flag_value),
        .transfer_sets_flags (transfer_sets_flags),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .write_data          (write_data),
        .write_enable        (write_enable),
        .stack_address       (stack_address),
        .branch_taken        (branch_taken),
        .acc_out             (acc_out),
        .x_out               (x_out),
        .y_out               (y_out),
        .sp_out              (sp_out),
        .status_out          (status_out)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver stalls
    initial
    begin
        out_ready  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = idle_len() - 1;
                out_ready  <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [7:0] get_gpr(input logic [1:0] sel);
        case (sel)
            REG_A:   return reg_a;
            REG_X:   return reg_x;
            REG_Y:   return reg_y;
            default: return reg_sp;
        endcase
    endfunction

    function automatic void put_gpr(input logic [1:0] sel, input logic [7:0] v);
        case (sel)
            REG_A:   reg_a = v;
            REG_X:   reg_x = v;
            REG_Y:   reg_y = v;
            default: reg_sp = v;
        endcase
    endfunction

    function automatic void set_nz(input logic [7:0] v);
        reg_p[FLAG_Z] = (v == 8'h00);
        reg_p[FLAG_N] = v[7];
    endfunction

    function automatic logic [7:0] shift_byte(input logic [7:0] v, input shift_t kind);
        logic [7:0] r;
        logic       cin;
        cin = reg_p[FLAG_C];
        case (kind)
            SH_ASL:
            begin
                reg_p[FLAG_C] = v[7];
                r = {v[6:0], 1'b0};
            end
            SH_ROL:
            begin
                reg_p[FLAG_C] = v[7];
                r = {v[6:0], cin};
            end
            SH_LSR:
            begin
                reg_p[FLAG_C] = v[0];
                r = {1'b0, v[7:1]};
            end
            default:
            begin
                reg_p[FLAG_C] = v[0];
                r = {cin, v[7:1]};
            end
        endcase
        set_nz(r);
        return r;
    endfunction

    // executes one item on the shadow registers
    function automatic exec_result_t execute_item(input exec_item_t it);
        exec_result_t res;
        logic [7:0]   m;
        logic [7:0]   v;
        logic [8:0]   sum;
        logic [4:0]   k;
        logic         cin;
        res       = '0;
        res.saddr = {1'b1, 8'h00};
        case (it.func)
            FN_LOAD:
            begin
                put_gpr(it.rsel, it.operand);
                set_nz(it.operand);
            end
            FN_STORE:
            begin
                res.wdata = get_gpr(it.rsel);
                res.wen   = 1'b1;
            end
            FN_ADD, FN_SUB:
            begin
                m   = (it.func == FN_SUB) ? ~it.operand : it.operand;
                sum = {1'b0, reg_a} + {1'b0, m} + {8'd0, reg_p[FLAG_C]};
                reg_p[FLAG_C] = sum[8];
                reg_p[FLAG_V] = (reg_a[7] ^ sum[7]) & (m[7] ^ sum[7]);
                reg_a = sum[7:0];
                set_nz(reg_a);
            end
            FN_AND:
            begin
                reg_a = reg_a & it.operand;
                set_nz(reg_a);
            end
            FN_OR:
            begin
                reg_a = reg_a | it.operand;
                set_nz(reg_a);
            end
            FN_XOR:
            begin
                reg_a = reg_a ^ it.operand;
                set_nz(reg_a);
            end
            FN_CMP:
            begin
                v = get_gpr(it.rsel);
                reg_p[FLAG_C] = (v >= it.operand);
                set_nz(v - it.operand);
            end
            FN_BIT:
            begin
                reg_p[FLAG_Z] = ((reg_a & it.operand) == 8'h00);
                reg_p[FLAG_N] = it.operand[7];
                reg_p[FLAG_V] = it.operand[6];
            end
            FN_ASL, FN_LSR, FN_ROL, FN_ROR:
            begin
                k = it.func - FN_ASL;
                if (it.on_mem)
                begin
                    res.wdata = shift_byte(it.operand, shift_t'(k[1:0]));
                    res.wen   = 1'b1;
                end
                else
                begin
                    reg_a = shift_byte(reg_a, shift_t'(k[1:0]));
                end
            end
            FN_INC, FN_DEC:
            begin
                v = it.on_mem ? it.operand : get_gpr(it.rsel);
                v = (it.func == FN_INC) ? v + 8'd1 : v - 8'd1;
                set_nz(v);
                if (it.on_mem)
                begin
                    res.wdata = v;
                    res.wen   = 1'b1;
                end
                else
                begin
                    put_gpr(it.rsel, v);
                end
            end
            FN_XFER:
            begin
                v = get_gpr(it.ssel);
                put_gpr(it.rsel, v);
                if (it.tflags)
                    set_nz(v);
            end
            FN_FLAG:
            begin
                if (it.fsel != FLAG_B && it.fsel != FLAG_U)
                    reg_p[it.fsel] = it.fval;
            end
            FN_RLA:
            begin
                cin = reg_p[FLAG_C];
                reg_p[FLAG_C] = it.operand[7];
                res.wdata = {it.operand[6:0], cin};
                res.wen   = 1'b1;
                reg_a = reg_a & res.wdata;
                set_nz(reg_a);
            end
            FN_BRA:
                res.taken = (reg_p[it.fsel] == it.fval);
            FN_PUSHA, FN_PUSHP:
            begin
                res.saddr = {1'b1, reg_sp};
                res.wdata = (it.func == FN_PUSHA) ? reg_a : (reg_p | PUSH_P_MASK);
                res.wen   = 1'b1;
                reg_sp    = reg_sp - 8'd1;
            end
            FN_PULLA, FN_PULLP:
            begin
                reg_sp    = reg_sp + 8'd1;
                res.saddr = {1'b1, reg_sp};
                if (it.func == FN_PULLA)
                begin
                    reg_a = it.operand;
                    set_nz(it.operand);
                end
                else
                begin
                    v = it.operand;
                    v[FLAG_B] = 1'b0;
                    v[FLAG_U] = 1'b1;
                    reg_p = v;
                end
            end
            default:
            begin
            end
        endcase
        res.a  = reg_a;
        res.x  = reg_x;
        res.y  = reg_y;
        res.sp = reg_sp;
        res.p  = reg_p;
        return res;
    endfunction

    // entered and left at a falling edge
    task automatic send_item(input exec_item_t it);
        int gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        func                <= it.func;
        reg_sel             <= it.rsel;
        src_sel             <= it.ssel;
        operand             <= it.operand;
        on_memory           <= it.on_mem;
        flag_sel            <= it.fsel;
        flag_value          <= it.fval;
        transfer_sets_flags <= it.tflags;
        in_valid            <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        step_results_q.push_back(execute_item(it));
        @(negedge clk);
    endtask

    task automatic issue(input logic [4:0] f, input logic [1:0] rs, input logic [1:0] ss,
                         input logic [7:0] op, input logic om, input logic [2:0] fs,
                         input logic fv, input logic tf);
        exec_item_t it;
        it = '{func: f, rsel: rs, ssel: ss, operand: op, on_mem: om,
               fsel: fs, fval: fv, tflags: tf};
        send_item(it);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (step_results_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [8:0] exp, input logic [8:0] act);
        if (exp !== act)
        begin
            $error("%s: expected %0h, got %0h", name, exp, act);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        exec_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (step_results_q.size() == 0)
            begin
                $error("result item with no expectation pending");
                errors++;
            end
            else
            begin
                e = step_results_q.pop_front();
                check_field("write_data", 9'(e.wdata), 9'(write_data));
                check_field("write_enable", 9'(e.wen), 9'(write_enable));
                check_field("stack_address", e.saddr, stack_address);
                check_field("branch_taken", 9'(e.taken), 9'(branch_taken));
                check_field("acc_out", 9'(e.a), 9'(acc_out));
                check_field("x_out", 9'(e.x), 9'(x_out));
                check_field("y_out", 9'(e.y), 9'(y_out));
                check_field("sp_out", 9'(e.sp), 9'(sp_out));
                check_field("status_out", 9'(e.p), 9'(status_out));
            end
        end
    end

    task automatic test_reset_values();
        issue(FN_NOP, REG_A, REG_A, 8'h00, 1'b0, FLAG_C, 1'b0, 1'b0);
    endtask

    task automatic test_load_store();
        issue(FN_LOAD, REG_A, REG_A, 8'h80, 1'b0, FLAG_C, 1'b0, 1'b0);
        issue(FN_LOAD, REG_X, REG_A, 8'h00, 1'b0, FLAG_C, 1'b0, 1'b0);
        issue(FN_STORE, REG_SP, REG_A, 8'hFF, 1'b1, FLAG_N, 1'b1, 1'b1);
    endtask

    // page-one wrap in both directions
    task automatic test_stack();
        issue(FN_LOAD, REG_SP, REG_A, 8'h00, 1'b0, FLAG_C, 1'b0, 1'b0);
        issue(FN_PUSHA, REG_A, REG_A, 8'h00, 1'b0, FLAG_C, 1'b0, 1'b0);
        issue(FN_PULLP, REG_A, REG_A, 8'hFF, 1'b0, FLAG_C, 1'b0, 1'b0);
        issue(FN_PUSHP, REG_A, REG_A, 8'h00, 1'b0, FLAG_C, 1'b0, 1'b0);
        issue(FN_PULLA, REG_A, REG_A, 8'h00, 1'b0, FLAG_C, 1'b0, 1'b0);
    endtask

    // decimal flag left set by the status pull
    task automatic test_arith();
        issue(FN_FLAG, REG_A, REG_A, 8'h00, 1'b0, FLAG_C, 1'b0, 1'b0);
        issue(FN_LOAD, REG_A, REG_A, 8'h7F, 1'b0, FLAG_C, 1'b0, 1'b0);
        issue(FN_ADD, REG_A, REG_A, 8'h01, 1'b0, FLAG_C, 1'b0, 1'b0);
        issue(FN_SUB, REG_A, REG_A, 8'h80, 1'b0, FLAG_C, 1'b0, 1'b0);
        issue(FN_CMP, REG_X, REG_A, 8'h00, 1'b0, FLAG_C, 1'b0, 1'b0);
    endtask

    task automatic test_logic_bit();
        issue(FN_XOR, REG_A, REG_A, 8'hFF, 1'b0, FLAG_C, 1'b0, 1'b0);
        issue(FN_BIT, REG_A, REG_A, 8'hC0, 1'b0, FLAG_C, 1'b0, 1'b0);
    endtask

    task automatic test_shifts();
        issue(FN_ASL, REG_A, REG_A, 8'hFF, 1'b1, FLAG_C, 1'b0, 1'b0);
        issue(FN_ROR, REG_Y, REG_A, 8'h00, 1'b0, FLAG_C, 1'b0, 1'b0);
        issue(FN_RLA, REG_A, REG_A, 8'h81, 1'b0, FLAG_C, 1'b0, 1'b0);
    endtask

    task automatic test_incdec_xfer();
        issue(FN_INC, REG_SP, REG_A, 8'h00, 1'b0, FLAG_C, 1'b0, 1'b0);
        issue(FN_DEC, REG_A, REG_A, 8'h00, 1'b1, FLAG_C, 1'b0, 1'b0);
        issue(FN_XFER, REG_SP, REG_X, 8'h00, 1'b0, FLAG_C, 1'b0, 1'b1);
    endtask

    task automatic test_flags_branch();
        issue(FN_FLAG, REG_A, REG_A, 8'h00, 1'b0, FLAG_B, 1'b1, 1'b0);
        issue(FN_FLAG, REG_A, REG_A, 8'h00, 1'b0, FLAG_U, 1'b0, 1'b0);
        issue(FN_BRA, REG_A, REG_A, 8'h00, 1'b0, FLAG_N, 1'b1, 1'b0);
        issue(5'd31, REG_A, REG_A, 8'h00, 1'b0, FLAG_C, 1'b0, 1'b0);
    endtask

    task automatic test_random();
        exec_item_t it;
        logic [7:0] edges [6];
        edges = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
        for (int c = 0; c < CHUNKS; c++)
        begin
            idle_on = (c == 0) || ($urandom_range(0, 3) != 0);
            for (int n = 0; n < CHUNK_ITEMS; n++)
            begin
                it.func    = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(24, 31))
                                                          : 5'($urandom_range(0, 23));
                it.rsel    = 2'($urandom_range(0, 3));
                it.ssel    = 2'($urandom_range(0, 3));
                it.operand = ($urandom_range(0, 3) == 0) ? edges[$urandom_range(0, 5)]
                                                         : 8'($urandom_range(0, 255));
                it.on_mem  = 1'($urandom_range(0, 1));
                it.fsel    = 3'($urandom_range(0, 7));
                it.fval    = 1'($urandom_range(0, 1));
                it.tflags  = 1'($urandom_range(0, 1));
                send_item(it);
            end
            wait_drained();
        end
    endtask

    initial
    begin
        idle_on             = 1'b1;
        rst_n               = 1'b0;
        in_valid            = 1'b0;
        func                = FN_NOP;
        reg_sel             = REG_A;
        src_sel             = REG_A;
        operand             = 8'h00;
        on_memory           = 1'b0;
        flag_sel            = FLAG_C;
        flag_value          = 1'b0;
        transfer_sets_flags = 1'b0;
        reg_a               = 8'h00;
        reg_x               = 8'h00;
        reg_y               = 8'h00;
        reg_sp              = SP_RESET;
        reg_p               = STATUS_RESET;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_values();
        test_load_store();
        test_stack();
        test_arith();
        test_logic_bit();
        test_shifts();
        test_incdec_xfer();
        test_flags_branch();
        wait_drained();
        test_random();

        in_valid <= 1'b0;
        while (step_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
